### hw/rtl/ast_pkg.sv
// Package for the alarm slot table: slot count, field widths, command codes
// and the request/response types of the shared add/compare unit.
// No dependencies.
`default_nettype none

package ast_pkg;

   localparam int NUM_SLOTS  = 8;
   localparam int SLOT_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int CMD_W      = 2;
   localparam int TICK_W     = 32;
   localparam int INDEX_W    = 3;
   localparam int SLOT_NUM_W = 4;

   localparam logic [CMD_W-1:0] CMD_TICK   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ALLOC  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_REARM  = 2'd2;
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   localparam logic KIND_ALLOC  = 1'b0;
   localparam logic KIND_EXPIRY = 1'b1;

   typedef struct packed {
      logic [TICK_W-1:0] opa;
      logic [TICK_W-1:0] opb;
   } alu_req_type;

   typedef struct packed {
      logic [TICK_W-1:0] sum;
      logic              eq;
   } alu_rsp_type;

endpackage

`default_nettype wire

### hw/rtl/ast_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module ast_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  wire logic                             clock,
   input  wire logic                             wr_en,
   input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                 wr_data,
   input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

### hw/rtl/ast_alu.sv
// Shared 32-bit add and equality-compare unit of the alarm slot table.
// Depends on ast_pkg.
`default_nettype none

module ast_alu (
   input  wire ast_pkg::alu_req_type alu_req,
   output ast_pkg::alu_rsp_type      alu_rsp
);

   import ast_pkg::*;

   // Counter advance and alarm-point sums wrap modulo 2^32.
   always_comb begin
      alu_rsp.sum = alu_req.opa + alu_req.opb;
      alu_rsp.eq  = (alu_req.opa == alu_req.opb);
   end

endmodule

`default_nettype wire

### hw/rtl/alarm_slot_table.sv
// Top level of the alarm slot table: command sequencer, slot status and
// notify flags. Depends on ast_pkg, ast_ram and ast_alu.
//
// Usage:
//   A command transaction is taken at a rising edge with start high and busy
//   low. req_cmd selects tick, allocate or rearm; any other code is dropped.
//   Results appear on rsp_* for one cycle, marked by rsp_strobe, and cannot
//   be held off by the receiver.
//   Allocate: the reply (slot number, or the slot count when no
//     slot is free) shows in the cycle after the transaction; busy stays low.
//   Rearm: no result.
//   Tick: busy through the scan, last and flush states. The shared
//     unit compares one alarm point per cycle as the alarm RAM streams out
//     through its registered read port. Expiry events leave in ascending
//     slot order. Each is held until the next expiring notifying slot is
//     found or the scan ends, so the last one can carry rsp_last_of_run; the
//     last one shows in the same cycle that busy drops. The next command
//     is taken once the sequencer is back in idle.
//   Reset (synchronous): counter zero, all slots free, notify flags clear,
//     sequencer idle. Alarm points are not cleared; only written slots can
//     ever expire.
`default_nettype none

module alarm_slot_table (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   output logic                                 busy,
   input  wire logic [ast_pkg::CMD_W-1:0]       req_cmd,
   input  wire logic [ast_pkg::TICK_W-1:0]      req_delay_ticks,
   input  wire logic [ast_pkg::INDEX_W-1:0]     req_slot_index,
   input  wire logic                            req_want_notify,
   output logic                                 rsp_strobe,
   output logic                                 rsp_result_kind,
   output logic      [ast_pkg::SLOT_NUM_W-1:0]  rsp_slot_number,
   output logic                                 rsp_last_of_run
);

   import ast_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_LAST,
      ST_FLUSH
   } seq_state_type;

   typedef enum logic [1:0] {
      SLOT_FREE,
      SLOT_PENDING,
      SLOT_EXPIRED
   } slot_state_type;

   seq_state_type     state_ff, state_in;
   slot_state_type    status_ff [NUM_SLOTS];
   logic              notify_ff [NUM_SLOTS];
   logic [TICK_W-1:0] tick_count_ff;
   logic [SLOT_W-1:0] scan_ff;
   logic              cmp_vld_ff;
   logic [SLOT_W-1:0] cmp_idx_ff;
   logic              held_vld_ff;
   logic [SLOT_W-1:0] held_idx_ff;

   logic                  rsp_strobe_ff;
   logic                  rsp_kind_ff;
   logic [SLOT_NUM_W-1:0] rsp_slot_ff;
   logic                  rsp_last_ff;

   alu_req_type       alu_req;
   alu_rsp_type       alu_rsp;
   logic [TICK_W-1:0] ram_rdata;
   logic              ram_we;
   logic [SLOT_W-1:0] ram_waddr;

   logic              accept;
   logic              free_found;
   logic [SLOT_W-1:0] free_idx;
   logic              rearm_ok;
   logic              hit;

   assign accept   = start && (state_ff == ST_IDLE);
   assign busy     = (state_ff != ST_IDLE);
   assign rearm_ok = ({1'b0, req_slot_index} < (INDEX_W + 1)'(NUM_SLOTS));

   // Lowest free slot.
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
         if (status_ff[i] == SLOT_FREE) begin
            free_found = 1'b1;
            free_idx   = SLOT_W'(i);
         end
      end
   end

   // Idle: advance the counter or form an alarm point. Busy: compare.
   always_comb begin
      if (state_ff == ST_IDLE) begin
         alu_req.opa = tick_count_ff;
         alu_req.opb = (req_cmd == CMD_TICK) ? TICK_W'(1) : req_delay_ticks;
      end else begin
         alu_req.opa = ram_rdata;
         alu_req.opb = tick_count_ff;
      end
   end

   ast_alu u_alu (
      .alu_req (alu_req),
      .alu_rsp (alu_rsp)
   );

   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = free_idx;
      if (accept) begin
         case (req_cmd)
            CMD_ALLOC: begin
               ram_we = free_found;
            end
            CMD_REARM: begin
               ram_we    = rearm_ok;
               ram_waddr = SLOT_W'(req_slot_index);
            end
            default: begin
               ram_we = 1'b0;
            end
         endcase
      end
   end

   ast_ram #(
      .WIDTH (TICK_W),
      .DEPTH (NUM_SLOTS)
   ) u_alarm_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (alu_rsp.sum),
      .rd_addr (scan_ff),
      .rd_data (ram_rdata)
   );

   assign hit = cmp_vld_ff && (status_ff[cmp_idx_ff] == SLOT_PENDING) && alu_rsp.eq;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_cmd == CMD_TICK)) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_ff == SLOT_W'(NUM_SLOTS - 1)) begin
               state_in = ST_LAST;
            end
         end
         ST_LAST: begin
            state_in = ST_FLUSH;
         end
         ST_FLUSH: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         tick_count_ff <= '0;
         scan_ff       <= '0;
         cmp_vld_ff    <= 1'b0;
         cmp_idx_ff    <= '0;
         held_vld_ff   <= 1'b0;
         held_idx_ff   <= '0;
         rsp_strobe_ff <= 1'b0;
         rsp_kind_ff   <= KIND_ALLOC;
         rsp_slot_ff   <= '0;
         rsp_last_ff   <= 1'b0;
         for (int i = 0; i < NUM_SLOTS; i++) begin
            status_ff[i] <= SLOT_FREE;
            notify_ff[i] <= 1'b0;
         end
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= 1'b0;
         cmp_vld_ff    <= (state_ff == ST_SCAN);
         cmp_idx_ff    <= scan_ff;

         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  case (req_cmd)
                     CMD_TICK: begin
                        tick_count_ff <= alu_rsp.sum;
                        scan_ff       <= '0;
                        held_vld_ff   <= 1'b0;
                     end
                     CMD_ALLOC: begin
                        if (free_found) begin
                           status_ff[free_idx] <= SLOT_PENDING;
                           notify_ff[free_idx] <= req_want_notify;
                        end
                        rsp_strobe_ff <= 1'b1;
                        rsp_kind_ff   <= KIND_ALLOC;
                        rsp_slot_ff   <= free_found ? SLOT_NUM_W'(free_idx)
                                                    : SLOT_NUM_W'(NUM_SLOTS);
                        rsp_last_ff   <= 1'b1;
                     end
                     CMD_REARM: begin
                        if (rearm_ok) begin
                           status_ff[SLOT_W'(req_slot_index)] <= SLOT_PENDING;
                        end
                     end
                     default: begin
                        // Drop unused command codes.
                     end
                  endcase
               end
            end
            ST_SCAN: begin
               if (scan_ff != SLOT_W'(NUM_SLOTS - 1)) begin
                  scan_ff <= scan_ff + SLOT_W'(1);
               end
            end
            ST_FLUSH: begin
               scan_ff <= '0;
               if (held_vld_ff) begin
                  rsp_strobe_ff <= 1'b1;
                  rsp_kind_ff   <= KIND_EXPIRY;
                  rsp_slot_ff   <= SLOT_NUM_W'(held_idx_ff);
                  rsp_last_ff   <= 1'b1;
               end
               held_vld_ff <= 1'b0;
            end
            default: begin
            end
         endcase

         // Expire a matching slot; if it notifies, release the previously held event as not last.
         if (hit) begin
            status_ff[cmp_idx_ff] <= SLOT_EXPIRED;
            if (notify_ff[cmp_idx_ff]) begin
               if (held_vld_ff) begin
                  rsp_strobe_ff <= 1'b1;
                  rsp_kind_ff   <= KIND_EXPIRY;
                  rsp_slot_ff   <= SLOT_NUM_W'(held_idx_ff);
                  rsp_last_ff   <= 1'b0;
               end
               held_vld_ff <= 1'b1;
               held_idx_ff <= cmp_idx_ff;
            end
         end
      end
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_result_kind = rsp_kind_ff;
   assign rsp_slot_number = rsp_slot_ff;
   assign rsp_last_of_run = rsp_last_ff;

endmodule

`default_nettype wire

### hw/rtl/ast_chk.sv
// Port-level checker for the alarm slot table, bound to the top level.
// Depends on ast_pkg and alarm_slot_table.
`default_nettype none

module ast_chk (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            start,
   input wire logic                            busy,
   input wire logic [ast_pkg::CMD_W-1:0]       req_cmd,
   input wire logic                            rsp_strobe,
   input wire logic                            rsp_result_kind,
   input wire logic [ast_pkg::SLOT_NUM_W-1:0]  rsp_slot_number,
   input wire logic                            rsp_last_of_run
);

   import ast_pkg::*;

   logic accept;
   assign accept = start && !busy;

   a_alloc_reply: assert property (@(posedge clock) disable iff (reset)
      accept && (req_cmd == CMD_ALLOC) |=>
         rsp_strobe && (rsp_result_kind == KIND_ALLOC) && rsp_last_of_run)
      else $error("allocate transaction without a single reply");

   a_quiet_cmds: assert property (@(posedge clock) disable iff (reset)
      accept && ((req_cmd == CMD_REARM) || (req_cmd == CMD_UNUSED) ||
                 (req_cmd == CMD_TICK)) |=> !rsp_strobe)
      else $error("result right after a rearm, tick or unused command");

   a_tick_busy: assert property (@(posedge clock) disable iff (reset)
      accept && (req_cmd == CMD_TICK) |=> busy)
      else $error("tick scan did not hold busy");

   a_expiry_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_result_kind == KIND_EXPIRY) |->
         (rsp_slot_number < SLOT_NUM_W'(NUM_SLOTS)))
      else $error("expiry event for a bad slot");

endmodule

bind alarm_slot_table ast_chk u_ast_chk (.*);

`default_nettype wire

### tb/sv/testbench.sv
// Self-checking testbench for alarm_slot_table: drives tick, allocate, rearm
// and unused command transactions and checks every result against a predictor.
// Depends on ast_pkg and the alarm_slot_table RTL.
module testbench;
   import ast_pkg::*;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int RANDOM_ITEMS   = 76;

   typedef enum logic [1:0] {SLOT_FREE, SLOT_PENDING, SLOT_EXPIRED} slot_state_type;

   typedef struct packed {
      logic                  kind;
      logic [SLOT_NUM_W-1:0] slot;
      logic                  last;
   } alarm_result_type;

   class alarm_scoreboard;
      logic [TICK_W-1:0] tick_count;
      slot_state_type    slot_state [NUM_SLOTS];
      logic [TICK_W-1:0] alarm_point [NUM_SLOTS];
      logic              notify_flag [NUM_SLOTS];
      alarm_result_type  awaited_q [$];
      int                failures;

      function new();
         tick_count = '0;
         failures = 0;
         for (int i = 0; i < NUM_SLOTS; i++) begin
            slot_state[i] = SLOT_FREE;
            alarm_point[i] = '0;
            notify_flag[i] = 1'b0;
         end
      endfunction

      // Predict the results of one accepted command transaction.
      function void note_command(logic [CMD_W-1:0] cmd, logic [TICK_W-1:0] delay,
                                 logic [INDEX_W-1:0] idx, logic notify);
         int fired [$];
         int claimed;
         alarm_result_type r;
         case (cmd)
            CMD_TICK: begin
               tick_count = tick_count + 1'b1;
               for (int i = 0; i < NUM_SLOTS; i++) begin
                  if (slot_state[i] == SLOT_PENDING && alarm_point[i] == tick_count) begin
                     slot_state[i] = SLOT_EXPIRED;
                     if (notify_flag[i])
                        fired.push_back(i);
                  end
               end
               for (int k = 0; k < fired.size(); k++) begin
                  r.kind = KIND_EXPIRY;
                  r.slot = SLOT_NUM_W'(fired[k]);
                  r.last = (k == fired.size() - 1);
                  awaited_q.push_back(r);
               end
            end
            CMD_ALLOC: begin
               claimed = NUM_SLOTS;
               for (int i = 0; i < NUM_SLOTS; i++) begin
                  if (claimed == NUM_SLOTS && slot_state[i] == SLOT_FREE) begin
                     claimed = i;
                     slot_state[i] = SLOT_PENDING;
                     notify_flag[i] = notify;
                     alarm_point[i] = tick_count + delay;
                  end
               end
               r.kind = KIND_ALLOC;
               r.slot = SLOT_NUM_W'(claimed);
               r.last = 1'b1;
               awaited_q.push_back(r);
            end
            CMD_REARM: begin
               if (int'(idx) < NUM_SLOTS) begin
                  alarm_point[idx] = tick_count + delay;
                  slot_state[idx] = SLOT_PENDING;
               end
            end
            default: ;
         endcase
      endfunction

      function void check_result(logic kind, logic [SLOT_NUM_W-1:0] slot, logic last);
         alarm_result_type want;
         if (awaited_q.size() == 0) begin
            $error("unexpected result: result_kind %0d slot_number %0d last_of_run %0d",
                   kind, slot, last);
            failures++;
            return;
         end
         want = awaited_q.pop_front();
         if (kind !== want.kind) begin
            $error("result_kind mismatch: expected %0d, actual %0d", want.kind, kind);
            failures++;
         end
         if (slot !== want.slot) begin
            $error("slot_number mismatch: expected %0d, actual %0d", want.slot, slot);
            failures++;
         end
         if (last !== want.last) begin
            $error("last_of_run mismatch: expected %0d, actual %0d", want.last, last);
            failures++;
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic [CMD_W-1:0]      req_cmd;
   logic [TICK_W-1:0]     req_delay_ticks;
   logic [INDEX_W-1:0]    req_slot_index;
   logic                  req_want_notify;
   logic                  rsp_strobe;
   logic                  rsp_result_kind;
   logic [SLOT_NUM_W-1:0] rsp_slot_number;
   logic                  rsp_last_of_run;

   alarm_scoreboard alarm_sb;
   int              idle_cycles;
   bit              no_idle;

   alarm_slot_table dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_cmd         (req_cmd),
      .req_delay_ticks (req_delay_ticks),
      .req_slot_index  (req_slot_index),
      .req_want_notify (req_want_notify),
      .rsp_strobe      (rsp_strobe),
      .rsp_result_kind (rsp_result_kind),
      .rsp_slot_number (rsp_slot_number),
      .rsp_last_of_run (rsp_last_of_run)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_strobe)
         alarm_sb.check_result(rsp_result_kind, rsp_slot_number, rsp_last_of_run);
   end

   // Restart the count on any transaction in either direction.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   task automatic send_command(logic [CMD_W-1:0] cmd, logic [TICK_W-1:0] delay,
                               logic [INDEX_W-1:0] idx, logic notify);
      int gap;
      if ($urandom_range(0, 9) == 0)
         no_idle = !no_idle;
      gap = no_idle ? 0 : $urandom_range(0, 15);
      repeat (gap) begin
         @(negedge clock);
         start <= 1'b0;
         req_cmd <= CMD_W'($urandom_range(0, 3));
         req_delay_ticks <= $urandom;
         req_slot_index <= INDEX_W'($urandom_range(0, 7));
         req_want_notify <= 1'($urandom_range(0, 1));
      end
      @(negedge clock);
      start <= 1'b1;
      req_cmd <= cmd;
      req_delay_ticks <= delay;
      req_slot_index <= idx;
      req_want_notify <= notify;
      do
         @(posedge clock);
      while (busy);
      alarm_sb.note_command(cmd, delay, idx, notify);
   endtask

   // Mostly short delays so alarms fire within the run; now and then any value.
   function automatic logic [TICK_W-1:0] pick_delay();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 80)
         return TICK_W'($urandom_range(1, 6));
      else if (roll < 85)
         return '0;
      else
         return $urandom;
   endfunction

   initial begin
      int roll;
      alarm_sb = new();
      no_idle = 1'b0;
      reset = 1'b1;
      start = 1'b0;
      req_cmd = CMD_TICK;
      req_delay_ticks = '0;
      req_slot_index = '0;
      req_want_notify = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: unused code, empty tick, allocation order, zero and maximum
      // delay, silent expiry, rearm of free and expired slots, full table.
      send_command(CMD_UNUSED, $urandom, INDEX_W'($urandom_range(0, 7)), 1'b1);
      send_command(CMD_TICK, '1, '1, 1'b1);
      send_command(CMD_ALLOC, '0, '0, 1'b1);
      send_command(CMD_ALLOC, '1, '1, 1'b1);
      send_command(CMD_ALLOC, 32'd1, 3'd5, 1'b1);
      send_command(CMD_ALLOC, 32'd1, 3'd2, 1'b0);
      send_command(CMD_ALLOC, 32'd2, 3'd0, 1'b1);
      send_command(CMD_REARM, 32'd1, 3'd5, 1'b0);
      send_command(CMD_TICK, '0, '0, 1'b0);
      send_command(CMD_ALLOC, 32'd1, 3'd0, 1'b1);
      send_command(CMD_ALLOC, 32'd1, 3'd0, 1'b1);
      send_command(CMD_REARM, 32'd1, 3'd2, 1'b0);
      send_command(CMD_REARM, 32'd1, 3'd0, 1'b1);
      send_command(CMD_TICK, '0, '0, 1'b0);
      send_command(CMD_ALLOC, 32'd3, 3'd1, 1'b1);
      for (int s = 0; s < NUM_SLOTS; s++)
         send_command(CMD_REARM, 32'd1, INDEX_W'(s), 1'b0);
      send_command(CMD_TICK, '0, '0, 1'b0);

      // Random: ticks and rearms dominate so slots keep firing.
      repeat (RANDOM_ITEMS) begin
         roll = $urandom_range(0, 99);
         if (roll < 45)
            send_command(CMD_TICK, $urandom, INDEX_W'($urandom_range(0, 7)),
                         1'($urandom_range(0, 1)));
         else if (roll < 60)
            send_command(CMD_ALLOC, pick_delay(), INDEX_W'($urandom_range(0, 7)),
                         1'($urandom_range(0, 1)));
         else if (roll < 94)
            send_command(CMD_REARM, pick_delay(), INDEX_W'($urandom_range(0, 7)),
                         1'($urandom_range(0, 1)));
         else
            send_command(CMD_UNUSED, $urandom, INDEX_W'($urandom_range(0, 7)),
                         1'($urandom_range(0, 1)));
      end
      @(negedge clock);
      start <= 1'b0;

      while (alarm_sb.awaited_q.size() != 0)
         @(posedge clock);
      // Hold a little longer to catch stray results.
      repeat (NUM_SLOTS + 6) @(posedge clock);
      if (alarm_sb.failures == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end
endmodule
